// File: rtl/dcfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_pkg
// shared constants, types and codes of the delimited command frame receiver
// ----------------------------------------------------------------------------
package dcfr_pkg;

    localparam int FRAME_BYTES = 15;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int ADDR_W      = CNT_W + 1;
    localparam int RAM_DEPTH   = 2 ** ADDR_W;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_FIRST_BYTE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_SECOND_BYTE = 2'd2;

    localparam logic [BYTE_W-1:0] RST_START_BYTE      = 8'h97;
    localparam logic [BYTE_W-1:0] RST_END_FIRST_BYTE  = 8'hF0;
    localparam logic [BYTE_W-1:0] RST_END_SECOND_BYTE = 8'hA5;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_first_byte;
        logic [BYTE_W-1:0] end_second_byte;
    } t_cfg;

    typedef struct packed {
        logic              bank;
        logic [BYTE_W-1:0] cmd;
        logic [CNT_W-1:0]  pay;
    } t_frame_desc;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr_port;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_LOAD,
        BK_OUT
    } t_back_state;

endpackage

// File: rtl/dcfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/dcfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_front
// hunts for the start byte, stores frame bytes, detects the end pair
// ----------------------------------------------------------------------------
module dcfr_front
    import dcfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_q_full,
    output logic              o_push,
    output t_frame_desc       o_desc,
    output t_wr_port          o_wr
);

    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_hunting, n_hunting;
    logic              r_bank, n_bank;
    logic [BYTE_W-1:0] r_prev, n_prev;
    logic [BYTE_W-1:0] r_cmd, n_cmd;

    logic              accept;
    logic [CNT_W-1:0]  wr_fill;
    logic              wr_hunt;
    logic [CNT_W-1:0]  fill_inc;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        // store full: abandon the frame, the byte is checked as a start byte
        if (r_fill >= CNT_W'(FRAME_BYTES)) begin
            wr_fill = '0;
            wr_hunt = 1'b1;
        end else begin
            wr_fill = r_fill;
            wr_hunt = r_hunting;
        end
        fill_inc = wr_fill + CNT_W'(1);

        n_fill    = r_fill;
        n_hunting = r_hunting;
        n_bank    = r_bank;
        n_prev    = r_prev;
        n_cmd     = r_cmd;
        o_push    = 1'b0;

        if (accept) begin
            if (wr_hunt) begin
                if (i_byte == i_cfg.start_byte) begin
                    n_hunting = 1'b0;
                    n_fill    = CNT_W'(1);
                    n_prev    = i_byte;
                end else begin
                    n_hunting = 1'b1;
                    n_fill    = '0;
                end
            end else begin
                n_prev = i_byte;
                if (wr_fill == CNT_W'(1)) begin
                    n_cmd = i_byte;
                end
                if (i_byte == i_cfg.end_second_byte && r_prev == i_cfg.end_first_byte) begin
                    o_push    = 1'b1;
                    n_fill    = '0;
                    n_hunting = 1'b1;
                    n_bank    = ~r_bank;
                end else begin
                    n_fill    = fill_inc;
                    n_hunting = 1'b0;
                end
            end
        end

        o_desc.bank = r_bank;
        o_desc.cmd  = (wr_fill == CNT_W'(1)) ? i_byte : r_cmd;
        o_desc.pay  = (fill_inc > CNT_W'(4)) ? fill_inc - CNT_W'(4) : '0;

        o_wr.we   = accept;
        o_wr.addr = {r_bank, wr_fill};
        o_wr.data = i_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_hunting <= 1'b1;
            r_bank    <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_hunting <= n_hunting;
            r_bank    <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_cmd  <= n_cmd;
    end

endmodule

// File: rtl/dcfr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_queue
// two-entry queue of completed frame descriptors between front and back
// ----------------------------------------------------------------------------
module dcfr_queue
    import dcfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_desc i_desc,
    input  logic        i_pop,
    output logic        o_valid,
    output logic        o_full,
    output t_frame_desc o_head
);

    t_frame_desc r_entry [2];
    logic        r_rd_ptr, n_rd_ptr;
    logic        r_wr_ptr, n_wr_ptr;
    logic [1:0]  r_count, n_count;
    logic        do_push;
    logic        do_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_head  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

endmodule

// File: rtl/dcfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_back
// reads a completed frame back from the store and hands out its results
// ----------------------------------------------------------------------------
module dcfr_back
    import dcfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_frame_desc       i_head,
    output logic              o_pop,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [BYTE_W-1:0] i_rd_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_command,
    output logic [IDX_W-1:0]  o_payload_index,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_payload_valid,
    output logic              o_last
);

    t_back_state       r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_pvalid, n_pvalid;
    logic              r_last, n_last;

    assign o_rd_addr = {i_head.bank, CNT_W'(2) + r_idx};

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_byte   = r_byte;
        n_pvalid = r_pvalid;
        n_last   = r_last;
        o_pop    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_idx = '0;
                    if (i_head.pay == '0) begin
                        n_byte   = '0;
                        n_pvalid = 1'b0;
                        n_last   = 1'b1;
                        n_state  = BK_OUT;
                    end else begin
                        n_state = BK_FETCH;
                    end
                end
            end
            BK_FETCH: begin
                n_state = BK_LOAD;
            end
            BK_LOAD: begin
                n_byte   = i_rd_data;
                n_pvalid = 1'b1;
                n_last   = (r_idx + CNT_W'(1) == i_head.pay);
                n_state  = BK_OUT;
            end
            BK_OUT: begin
                if (i_ready) begin
                    if (r_last) begin
                        o_pop   = 1'b1;
                        n_state = BK_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = BK_FETCH;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_idx    <= '0;
            r_pvalid <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pvalid <= n_pvalid;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_valid         = (r_state == BK_OUT);
    assign o_command       = i_head.cmd;
    assign o_payload_index = IDX_W'(r_idx);
    assign o_payload_byte  = r_byte;
    assign o_payload_valid = r_pvalid;
    assign o_last          = r_last;

`ifndef NO_ASSERTIONS
    a_busy_has_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_IDLE) |-> i_q_valid)
        else $error("back end busy without a queued frame");

    a_last_matches_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_OUT && r_pvalid) |-> (r_last == (r_idx + CNT_W'(1) == i_head.pay)))
        else $error("last mark does not match payload count");

    a_empty_frame_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_OUT && !r_pvalid) |-> (r_last && r_idx == '0 && i_head.pay == '0))
        else $error("frame without payload gives a malformed result");

    a_pop_returns_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == BK_IDLE))
        else $error("back end did not return to idle after a frame");
`endif

endmodule

// File: rtl/delimited_command_frame_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_command_frame_receiver_core
// receives bytes, frames them between a start byte and an end byte pair, and
// emits the command byte, with each payload byte or alone, of every completed frame
// ----------------------------------------------------------------------------
// The input side takes one byte per cycle. A completed frame is queued for
// the back end, which hands out its results one at a time, each through a
// store read, an output load and a handoff, or a single result for a frame
// without payload. Two completed frames can wait in the queue, each in its
// own bank of the frame store; while both wait the input side holds tready
// low.
module delimited_command_frame_receiver_core
    import dcfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,     // [7:0] rx_byte
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [23:0]          o_m_tdata,     // [7:0] command, [11:8] payload_index,
                                                // [19:12] payload_byte, [23:20] zero
    output logic                 o_m_tuser,     // [0] payload_valid
    output logic                 o_m_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    t_cfg              r_cfg;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    logic              q_full;
    t_frame_desc       front_desc;
    t_frame_desc       q_head;
    t_wr_port          store_wr;
    logic [ADDR_W-1:0] store_rd_addr;
    logic [BYTE_W-1:0] store_rd_data;
    logic [BYTE_W-1:0] res_command;
    logic [IDX_W-1:0]  res_index;
    logic [BYTE_W-1:0] res_byte;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte      <= RST_START_BYTE;
            r_cfg.end_first_byte  <= RST_END_FIRST_BYTE;
            r_cfg.end_second_byte <= RST_END_SECOND_BYTE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_BYTE:      r_cfg.start_byte      <= i_cfg_data;
                REG_END_FIRST_BYTE:  r_cfg.end_first_byte  <= i_cfg_data;
                REG_END_SECOND_BYTE: r_cfg.end_second_byte <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dcfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_byte   (i_s_tdata),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_desc   (front_desc),
        .o_wr     (store_wr)
    );

    dcfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (store_wr.we),
        .i_wr_addr (store_wr.addr),
        .i_wr_data (store_wr.data),
        .i_rd_addr (store_rd_addr),
        .o_rd_data (store_rd_data)
    );

    dcfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (front_desc),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    dcfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_rd_addr       (store_rd_addr),
        .i_rd_data       (store_rd_data),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_command       (res_command),
        .o_payload_index (res_index),
        .o_payload_byte  (res_byte),
        .o_payload_valid (o_m_tuser),
        .o_last          (o_m_tlast)
    );

    assign o_m_tdata = {4'b0000, res_byte, res_index, res_command};

endmodule
